/* hw/rtl/dtw_pkg.sv */
// Shared types, codes and constants of the windowed time warping distance block.
`default_nettype none

package dtw_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int ACTION_W   = 2;
    localparam int ELEM_W     = 16;
    localparam int COST_W     = 32;

    localparam logic [ACTION_W-1:0] ACT_FIRST   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SECOND  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BAND_EN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_RATIO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COST_WEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NORM_EN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_SIZE  = 3'd4;

    localparam logic [COST_W-1:0] COST_INF = 32'hFFFF_FFFF;
    localparam logic [COST_W-1:0] COST_MAX = 32'hFFFF_FFFE;

    localparam logic [8:0]  RATIO_ONE     = 9'd256;
    localparam logic [8:0]  RATIO_RESET   = 9'd26;
    localparam logic [15:0] WEIGHT_RESET  = 16'd256;
    localparam logic [4:0]  FSIZE_RESET   = 5'd13;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LEN1,
        S_LEN1_WAIT,
        S_LEN2,
        S_LEN2_WAIT,
        S_SETUP,
        S_INIT,
        S_READ,
        S_CELL,
        S_ACC,
        S_SQRT,
        S_SQRT_WAIT,
        S_MUL,
        S_SUM,
        S_WRITE,
        S_NORM,
        S_NORM_WAIT,
        S_OUT
    } dtw_state_t;

    typedef struct packed {
        logic idle;
        logic div_len1;
        logic take_len1;
        logic div_len2;
        logic take_len2;
        logic setup;
        logic init;
        logic rd;
        logic visit;
        logic acc;
        logic sqrt_start;
        logic mul;
        logic sum;
        logic wr;
        logic div_norm;
        logic take_norm;
        logic load_out;
    } dtw_cmd_t;

    typedef struct packed {
        logic start;
        logic div_done;
        logic empty;
        logic skip;
        logic acc_done;
        logic sqrt_done;
        logic j_last;
        logic i_last;
        logic norm_needed;
        logic out_free;
    } dtw_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/dtw_if.sv */
// Handshake channel interfaces: input items, result items and register writes.
`default_nettype none

interface dtw_item_if import dtw_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic signed [ELEM_W-1:0]   element_value;

    modport source (output valid, output action, output element_value, input ready);
    modport sink   (input valid, input action, input element_value, output ready);
endinterface

interface dtw_result_if import dtw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COST_W-1:0]  distance;
    logic               unreachable;
    logic               overflowed;

    modport source (output valid, output distance, output unreachable, output overflowed,
                    input ready);
    modport sink   (input valid, input distance, input unreachable, input overflowed,
                    output ready);
endinterface

interface dtw_csr_if import dtw_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/dtw_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module dtw_div import dtw_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [COST_W-1:0] num,
    input  logic [COST_W-1:0] den,
    output logic              done,
    output logic [COST_W-1:0] quo
);

    localparam int CW = $clog2(COST_W + 1);

    logic [COST_W-1:0] quo_reg, rem_reg, den_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg, done_reg;
    logic [COST_W:0]   rem_sh, rem_diff;
    logic              fits;

    assign rem_sh   = {rem_reg, quo_reg[COST_W-1]};
    assign fits     = rem_sh >= {1'b0, den_reg};
    assign rem_diff = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(COST_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_diff[COST_W-1:0] : rem_sh[COST_W-1:0];
            quo_reg <= {quo_reg[COST_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

/* hw/rtl/dtw_sqrt.sv */
// Digit-by-digit integer square root, one root bit per cycle.
`default_nettype none

module dtw_sqrt #(
    parameter int SW = 36
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [SW-1:0]   rad,
    output logic            done,
    output logic [SW/2-1:0] root
);

    localparam int RW = SW / 2;
    localparam int CW = $clog2(RW + 1);

    logic [SW-1:0] rad_reg;
    logic [RW+1:0] rem_reg;
    logic [RW-1:0] root_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [RW+1:0] rem_sh, trial;
    logic          fits;

    assign rem_sh = {rem_reg[RW-1:0], rad_reg[SW-1:SW-2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(RW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[SW-3:0], 2'b00};
            rem_reg  <= fits ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[RW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

/* hw/rtl/dtw_dp.sv */
// Datapath: element stores, cost row memory, local cost arithmetic and result register.
`default_nettype none

module dtw_dp import dtw_pkg::*; #(
    parameter int MAX_FRAMES  = 256,
    parameter int FEATURE_DIM = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dtw_cmd_t                  cmd,
    output dtw_stat_t                 stat,
    input  logic                      feed_fire,
    input  logic [ACTION_W-1:0]       action,
    input  logic signed [ELEM_W-1:0]  element_value,
    input  logic                      csr_fire,
    input  logic [CFG_IDX_W-1:0]      csr_index,
    input  logic [CFG_DATA_W-1:0]     csr_data,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [COST_W-1:0]         distance,
    output logic                      unreachable,
    output logic                      overflowed
);

    localparam int DEPTH = MAX_FRAMES * FEATURE_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);
    localparam int LW    = $clog2(MAX_FRAMES + 1);
    localparam int FSW   = $clog2(FEATURE_DIM + 1);
    localparam int SW    = COST_W + 2 * (($clog2(FEATURE_DIM) + 1) / 2);
    localparam int RW    = SW / 2;

    // configuration
    logic            band_en_reg, norm_en_reg;
    logic [8:0]      ratio_reg;
    logic [15:0]     weight_reg;
    logic [4:0]      fsize_reg;

    // stores
    logic signed [ELEM_W-1:0] mem1 [DEPTH];
    logic signed [ELEM_W-1:0] mem2 [DEPTH];
    logic [COST_W-1:0]        rmem [MAX_FRAMES+1];
    logic [CNTW-1:0]          cnt1_reg, cnt2_reg;
    logic                     ovf_reg;

    // walk state
    logic [LW-1:0]            len1_reg, len2_reg, w_reg, i_reg, j_reg;
    logic [AW-1:0]            base1_reg, base2_reg;
    logic [FSW-1:0]           e_reg;
    logic                     v1_reg, v2_reg;
    logic signed [ELEM_W-1:0] rd1_reg, rd2_reg;
    logic [31:0]              sq_reg;
    logic [SW-1:0]            sum_reg;
    logic [COST_W-1:0]        up_reg, left_reg, diag_reg, m_reg, lc_reg, cell_reg, res_reg;

    logic                     out_valid_reg, unreach_reg, ovf_out_reg;
    logic [COST_W-1:0]        dist_reg;

    logic [FSW-1:0]           eff;
    logic [CNTW-1:0]          cap;
    logic                     app1, app2;
    logic [AW-1:0]            addr1, addr2;
    logic                     div_start, div_done, sqrt_done;
    logic [COST_W-1:0]        div_num, div_den, quo;
    logic [LW-1:0]            len_q;
    logic [8:0]               ratio_eff;
    logic [LW-1:0]            maxlen;
    logic [LW+8:0]            band_prod;
    logic [LW:0]              jw, iw;
    logic                     in_band;
    logic [COST_W-1:0]        min_lu, min3;
    logic signed [ELEM_W:0]   diff;
    logic signed [2*ELEM_W+1:0] sq_full;
    logic [RW-1:0]            root;
    logic [RW+15:0]           lc_prod;
    logic [COST_W:0]          cell_sum;
    logic                     rm_we;
    logic [COST_W-1:0]        rm_wdata;

    always_comb
    begin
        if (fsize_reg == 5'd0)
            eff = FSW'(1);
        else if (32'(fsize_reg) > FEATURE_DIM)
            eff = FSW'(FEATURE_DIM);
        else
            eff = FSW'(fsize_reg);
    end

    assign cap  = CNTW'(MAX_FRAMES * 32'(eff));
    assign app1 = feed_fire && (action == ACT_FIRST);
    assign app2 = feed_fire && (action == ACT_SECOND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_en_reg <= 1'b0;
            ratio_reg   <= RATIO_RESET;
            weight_reg  <= WEIGHT_RESET;
            norm_en_reg <= 1'b0;
            fsize_reg   <= FSIZE_RESET;
        end
        else if (csr_fire)
        begin
            case (csr_index)
                REG_BAND_EN:     band_en_reg <= csr_data[0];
                REG_BAND_RATIO:  ratio_reg   <= csr_data[8:0];
                REG_COST_WEIGHT: weight_reg  <= csr_data;
                REG_NORM_EN:     norm_en_reg <= csr_data[0];
                REG_FRAME_SIZE:  fsize_reg   <= csr_data[4:0];
                default:         ;
            endcase
        end
    end

    // fill counts and overflow; cleared when the result is posted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt1_reg <= '0;
            cnt2_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            cnt1_reg <= '0;
            cnt2_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            if (app1)
            begin
                if (cnt1_reg < cap)
                    cnt1_reg <= cnt1_reg + 1'b1;
                else
                    ovf_reg <= 1'b1;
            end
            if (app2)
            begin
                if (cnt2_reg < cap)
                    cnt2_reg <= cnt2_reg + 1'b1;
                else
                    ovf_reg <= 1'b1;
            end
        end
    end

    assign addr1 = base1_reg + AW'(e_reg);
    assign addr2 = base2_reg + AW'(e_reg);

    always_ff @(posedge clk)
    begin
        if (app1 && (cnt1_reg < cap))
            mem1[cnt1_reg[AW-1:0]] <= element_value;
        if (cmd.acc)
            rd1_reg <= mem1[addr1];
    end

    always_ff @(posedge clk)
    begin
        if (app2 && (cnt2_reg < cap))
            mem2[cnt2_reg[AW-1:0]] <= element_value;
        if (cmd.acc)
            rd2_reg <= mem2[addr2];
    end

    // shared divider: frame counts and normalization
    assign div_start = cmd.div_len1 || cmd.div_len2 || cmd.div_norm;

    always_comb
    begin
        if (cmd.div_norm)
        begin
            div_num = res_reg;
            div_den = COST_W'(len1_reg) + COST_W'(len2_reg);
        end
        else if (cmd.div_len2)
        begin
            div_num = COST_W'(cnt2_reg);
            div_den = COST_W'(eff);
        end
        else
        begin
            div_num = COST_W'(cnt1_reg);
            div_den = COST_W'(eff);
        end
    end

    dtw_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (quo)
    );

    dtw_sqrt #(.SW(SW)) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.sqrt_start),
        .rad   (sum_reg),
        .done  (sqrt_done),
        .root  (root)
    );

    assign len_q     = (quo > COST_W'(MAX_FRAMES)) ? LW'(MAX_FRAMES) : LW'(quo);
    assign ratio_eff = (ratio_reg > RATIO_ONE) ? RATIO_ONE : ratio_reg;
    assign maxlen    = (len1_reg > len2_reg) ? len1_reg : len2_reg;
    assign band_prod = (LW+9)'(maxlen) * (LW+9)'(ratio_eff);

    assign jw      = {1'b0, j_reg} + {1'b0, w_reg};
    assign iw      = {1'b0, i_reg} + {1'b0, w_reg};
    assign in_band = (jw >= {1'b0, i_reg}) && ({1'b0, j_reg} <= iw);

    assign min_lu = (left_reg < up_reg) ? left_reg : up_reg;
    assign min3   = (diag_reg < min_lu) ? diag_reg : min_lu;

    assign diff     = {rd1_reg[ELEM_W-1], rd1_reg} - {rd2_reg[ELEM_W-1], rd2_reg};
    assign sq_full  = diff * diff;
    assign lc_prod  = (RW+16)'(root) * (RW+16)'(weight_reg);
    assign cell_sum = {1'b0, m_reg} + {1'b0, lc_reg};

    always_comb
    begin
        rm_we    = cmd.init || cmd.wr;
        rm_wdata = cell_reg;
        if (cmd.init)
            rm_wdata = (j_reg == '0) ? '0 : COST_INF;
    end

    always_ff @(posedge clk)
    begin
        if (rm_we)
            rmem[j_reg] <= rm_wdata;
        if (cmd.rd)
            up_reg <= rmem[j_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            e_reg  <= '0;
        end
        else if (cmd.visit)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            e_reg  <= '0;
        end
        else if (cmd.acc)
        begin
            if (e_reg != eff)
                e_reg <= e_reg + 1'b1;
            v1_reg <= (e_reg != eff);
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_len1)
            len1_reg <= len_q;
        if (cmd.take_len2)
            len2_reg <= len_q;
        if (cmd.setup)
        begin
            w_reg     <= band_en_reg ? band_prod[LW+7:8] : LW'(MAX_FRAMES);
            i_reg     <= LW'(1);
            j_reg     <= '0;
            base1_reg <= '0;
            base2_reg <= '0;
            res_reg   <= COST_INF;
        end
        if (cmd.init)
            j_reg <= (j_reg == len2_reg) ? '0 : j_reg + 1'b1;
        if (cmd.visit)
        begin
            diag_reg <= up_reg;
            m_reg    <= min3;
            sum_reg  <= '0;
            if (stat.skip)
                cell_reg <= COST_INF;
        end
        if (cmd.acc)
        begin
            if (v1_reg)
                sq_reg <= sq_full[31:0];
            if (v2_reg)
                sum_reg <= sum_reg + SW'(sq_reg);
        end
        // scaled product (after the shift by 8) stays below 2^(RW+8), well under the saturation point
        if (cmd.mul)
            lc_reg <= COST_W'(lc_prod[RW+15:8]);
        if (cmd.sum)
            cell_reg <= (cell_sum > {1'b0, COST_MAX}) ? COST_MAX : cell_sum[COST_W-1:0];
        if (cmd.wr)
        begin
            left_reg <= cell_reg;
            if (j_reg == len2_reg)
            begin
                j_reg     <= '0;
                base2_reg <= '0;
                if (i_reg == len1_reg)
                    res_reg <= cell_reg;
                else
                begin
                    i_reg     <= i_reg + 1'b1;
                    base1_reg <= base1_reg + AW'(eff);
                end
            end
            else
            begin
                j_reg <= j_reg + 1'b1;
                if (j_reg != '0)
                    base2_reg <= base2_reg + AW'(eff);
            end
        end
        if (cmd.take_norm)
            res_reg <= quo;
    end

    // result register; hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            dist_reg    <= res_reg;
            unreach_reg <= (res_reg == COST_INF);
            ovf_out_reg <= ovf_reg;
        end
    end

    always_comb
    begin
        stat.start       = feed_fire && (action == ACT_COMPUTE);
        stat.div_done    = div_done;
        stat.empty       = (len1_reg == '0) || (len2_reg == '0);
        stat.skip        = (j_reg == '0) || !in_band || (min3 == COST_INF);
        stat.acc_done    = (e_reg == eff) && !v1_reg && !v2_reg;
        stat.sqrt_done   = sqrt_done;
        stat.j_last      = (j_reg == len2_reg);
        stat.i_last      = (i_reg == len1_reg);
        stat.norm_needed = norm_en_reg && (res_reg != COST_INF);
        stat.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign distance    = dist_reg;
    assign unreachable = unreach_reg;
    assign overflowed  = ovf_out_reg;

endmodule

`default_nettype wire

/* hw/rtl/dtw_ctrl.sv */
// Controller state machine that sequences the table walk.
`default_nettype none

module dtw_ctrl import dtw_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  dtw_stat_t stat,
    output dtw_cmd_t  cmd
);

    dtw_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (stat.start)
                    state_next = S_LEN1;
            end
            S_LEN1:
            begin
                cmd.div_len1 = 1'b1;
                state_next   = S_LEN1_WAIT;
            end
            S_LEN1_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.take_len1 = 1'b1;
                    state_next    = S_LEN2;
                end
            end
            S_LEN2:
            begin
                cmd.div_len2 = 1'b1;
                state_next   = S_LEN2_WAIT;
            end
            S_LEN2_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.take_len2 = 1'b1;
                    state_next    = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = stat.empty ? S_OUT : S_INIT;
            end
            S_INIT:
            begin
                cmd.init = 1'b1;
                if (stat.j_last)
                    state_next = S_READ;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CELL;
            end
            S_CELL:
            begin
                cmd.visit  = 1'b1;
                state_next = stat.skip ? S_WRITE : S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (stat.acc_done)
                    state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_SQRT_WAIT;
            end
            S_SQRT_WAIT:
            begin
                if (stat.sqrt_done)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.wr     = 1'b1;
                state_next = (stat.j_last && stat.i_last) ? S_NORM : S_READ;
            end
            S_NORM:
            begin
                if (stat.norm_needed)
                begin
                    cmd.div_norm = 1'b1;
                    state_next   = S_NORM_WAIT;
                end
                else
                    state_next = S_OUT;
            end
            S_NORM_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.take_norm = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/dtw_distance_windowed.sv */
// Top level of the windowed dynamic time warping distance block.
`default_nettype none

// Append items (action 0 or 1) are taken one per cycle while the block is
// idle and store one signed Q7.8 element each; appends past MAX_FRAMES frames
// are dropped and flagged. A compute item (action 2) holds the block busy
// while it walks the cost table: the two frame-count divisions and the
// optional normalization, seeding of the row memory, a visit to every cell of
// every row, and for every reachable cell inside the band the element reads
// plus the bit-serial square root and weighting (SW/2 is 18 for a 16-element
// frame). The single-port element stores and the shared square-root unit
// pace the walk. The result waits in an output register; appends are
// accepted while it waits, and the stores and overflow flag clear once it
// is posted.
module dtw_distance_windowed import dtw_pkg::*; #(
    parameter int MAX_FRAMES  = 256,
    parameter int FEATURE_DIM = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    dtw_item_if.sink      feed,
    dtw_result_if.source  result,
    dtw_csr_if.sink       csr
);

    dtw_cmd_t  cmd;
    dtw_stat_t stat;
    logic      feed_fire, csr_fire;

    assign feed.ready = cmd.idle;
    assign csr.ready  = 1'b1;
    assign feed_fire  = feed.valid && cmd.idle;
    assign csr_fire   = csr.valid;

    dtw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    dtw_dp #(
        .MAX_FRAMES  (MAX_FRAMES),
        .FEATURE_DIM (FEATURE_DIM)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .feed_fire     (feed_fire),
        .action        (feed.action),
        .element_value (feed.element_value),
        .csr_fire      (csr_fire),
        .csr_index     (csr.index),
        .csr_data      (csr.data),
        .out_ready     (result.ready),
        .out_valid     (result.valid),
        .distance      (result.distance),
        .unreachable   (result.unreachable),
        .overflowed    (result.overflowed)
    );

endmodule

`default_nettype wire

/* hw/rtl/dtw_chk.sv */
// Port-level checker for the distance block and its bind.
`default_nettype none

module dtw_chk import dtw_pkg::*; (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                feed_valid,
    input wire logic                feed_ready,
    input wire logic [ACTION_W-1:0] feed_action,
    input wire logic                res_valid,
    input wire logic                res_ready,
    input wire logic [COST_W-1:0]   res_distance,
    input wire logic                res_unreachable
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result item dropped before taken");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_distance))
        else $error("result distance changed while stalled");

    a_busy_after_compute: assert property (@(posedge clk) disable iff (!rst_n)
        feed_valid && feed_ready && (feed_action == ACT_COMPUTE) |=> !feed_ready)
        else $error("input taken during compute");

    a_unreach_inf: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_unreachable == (res_distance == COST_INF)))
        else $error("unreachable flag disagrees with distance");

endmodule

bind dtw_distance_windowed dtw_chk u_dtw_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .feed_valid      (feed.valid),
    .feed_ready      (feed.ready),
    .feed_action     (feed.action),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .res_distance    (result.distance),
    .res_unreachable (result.unreachable)
);

`default_nettype wire

/* dv/dtw_distance_windowed_tb.sv */
// Self-checking testbench for the windowed dynamic time warping distance block.
`default_nettype none

module dtw_distance_windowed_tb;
    import dtw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAMES_MAX = 256;
    localparam int DIM_MAX    = 16;
    localparam int MEM_DEPTH  = FRAMES_MAX * DIM_MAX;

    // action code with no meaning; the block must ignore it
    localparam logic [ACTION_W-1:0] ACT_IGNORED = 2'd3;

    typedef struct {
        logic [COST_W-1:0] distance;
        logic              unreachable;
        logic              overflowed;
    } dtw_outcome_t;

    logic clk = 1'b0;
    logic rst_n;

    dtw_item_if   feed_ch();
    dtw_result_if res_ch();
    dtw_csr_if    csr_ch();

    dtw_distance_windowed #(
        .MAX_FRAMES  (FRAMES_MAX),
        .FEATURE_DIM (DIM_MAX)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed_ch),
        .result (res_ch),
        .csr    (csr_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow copy of the block's registers and stores.
    logic              sh_band_en;
    logic [8:0]        sh_ratio;
    logic [15:0]       sh_weight;
    logic              sh_norm_en;
    logic [4:0]        sh_fsize;
    logic signed [15:0] first_mem [MEM_DEPTH];
    logic signed [15:0] second_mem [MEM_DEPTH];
    int unsigned       first_cnt;
    int unsigned       second_cnt;
    logic              drop_flag;

    dtw_outcome_t expected_costs [$];
    int           error_count;
    int           feed_idle_pct;
    int           result_stall_pct;
    int           items_sent;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic int unsigned frame_len();
        if (sh_fsize == 5'd0)
            return 1;
        if (sh_fsize > DIM_MAX)
            return DIM_MAX;
        return sh_fsize;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v -= root + b;
                root = (root >> 1) + b;
            end
            else
                root >>= 1;
            b >>= 2;
        end
        return root;
    endfunction

    function automatic logic [31:0] frame_cost(input int unsigned f1, input int unsigned f2,
                                               input int unsigned fs);
        longint unsigned acc;
        longint signed   d;
        longint unsigned c;
        acc = 0;
        for (int unsigned e = 0; e < fs; e++)
        begin
            d = longint'(first_mem[f1 * fs + e]) - longint'(second_mem[f2 * fs + e]);
            acc += longint'(d * d);
        end
        c = (floor_sqrt(acc) * longint'(sh_weight)) >> 8;
        return (c > COST_MAX) ? COST_MAX : c[31:0];
    endfunction

    function automatic logic [31:0] warp_cost();
        int unsigned fs, len1, len2, w, ratio, maxlen, js, je;
        logic [31:0] prev_row [FRAMES_MAX + 1];
        logic [31:0] cur_row [FRAMES_MAX + 1];
        logic [31:0] m;
        longint unsigned s;
        logic [31:0] res;
        fs = frame_len();
        len1 = first_cnt / fs;
        len2 = second_cnt / fs;
        if (len1 > FRAMES_MAX) len1 = FRAMES_MAX;
        if (len2 > FRAMES_MAX) len2 = FRAMES_MAX;
        if (len1 == 0 || len2 == 0)
            return COST_INF;
        ratio = (sh_ratio > RATIO_ONE) ? 256 : sh_ratio;
        maxlen = (len1 > len2) ? len1 : len2;
        w = sh_band_en ? (maxlen * ratio) >> 8 : FRAMES_MAX;
        prev_row[0] = '0;
        for (int unsigned j = 1; j <= len2; j++)
            prev_row[j] = COST_INF;
        for (int unsigned i = 1; i <= len1; i++)
        begin
            js = (i > w + 1) ? i - w : 1;
            je = (i + w < len2) ? i + w : len2;
            for (int unsigned j = 0; j <= len2; j++)
                cur_row[j] = COST_INF;
            for (int unsigned j = js; j <= je; j++)
            begin
                m = prev_row[j];
                if (cur_row[j-1] < m) m = cur_row[j-1];
                if (prev_row[j-1] < m) m = prev_row[j-1];
                if (m != COST_INF)
                begin
                    s = longint'(m) + longint'(frame_cost(i - 1, j - 1, fs));
                    cur_row[j] = (s > COST_MAX) ? COST_MAX : s[31:0];
                end
            end
            for (int unsigned j = 0; j <= len2; j++)
                prev_row[j] = cur_row[j];
        end
        res = prev_row[len2];
        if (sh_norm_en && res != COST_INF)
            res = res / (len1 + len2);
        return res;
    endfunction

    // Update shadow state for one accepted item; queue a result for compute.
    function automatic void predict_item(input logic [1:0] act, input logic signed [15:0] v);
        int unsigned cap;
        dtw_outcome_t o;
        cap = FRAMES_MAX * frame_len();
        if (act == ACT_FIRST)
        begin
            if (first_cnt < cap) first_mem[first_cnt++] = v;
            else drop_flag = 1'b1;
        end
        else if (act == ACT_SECOND)
        begin
            if (second_cnt < cap) second_mem[second_cnt++] = v;
            else drop_flag = 1'b1;
        end
        else if (act == ACT_COMPUTE)
        begin
            o.distance = warp_cost();
            o.unreachable = (o.distance == COST_INF);
            o.overflowed = drop_flag;
            expected_costs.push_back(o);
            first_cnt = 0;
            second_cnt = 0;
            drop_flag = 1'b0;
        end
    endfunction

    // Call at a rising edge; returns at the edge that accepted the item.
    task automatic send_item(input logic [1:0] act, input logic signed [15:0] v);
        while ($urandom_range(99) < feed_idle_pct)
        begin
            feed_ch.valid <= 1'b0;
            @(posedge clk);
        end
        feed_ch.valid <= 1'b1;
        feed_ch.action <= act;
        feed_ch.element_value <= v;
        @(posedge clk);
        while (!feed_ch.ready)
            @(posedge clk);
        predict_item(act, v);
        if (act != ACT_IGNORED) items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        csr_ch.valid <= 1'b1;
        csr_ch.index <= idx;
        csr_ch.data <= value;
        @(posedge clk);
        while (!csr_ch.ready)
            @(posedge clk);
        csr_ch.valid <= 1'b0;
        case (idx)
            REG_BAND_EN:     sh_band_en = value[0];
            REG_BAND_RATIO:  sh_ratio = value[8:0];
            REG_COST_WEIGHT: sh_weight = value;
            REG_NORM_EN:     sh_norm_en = value[0];
            REG_FRAME_SIZE:  sh_fsize = value[4:0];
            default: ;
        endcase
    endtask

    // Hold until every result is in, then let trailing appends settle.
    task automatic drain();
        feed_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_costs.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_elem();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(511)) - 16'sd256;
            default: return 16'($urandom);
        endcase
    endfunction

    // Append n1 and n2 elements, interleaved at random with optional ignored items, then compute.
    task automatic load_and_compute(input int n1, input int n2, input int noise_pct);
        int a, b;
        a = 0;
        b = 0;
        while (a < n1 || b < n2)
        begin
            if ($urandom_range(99) < noise_pct)
                send_item(ACT_IGNORED, rand_elem());
            if (b >= n2 || (a < n1 && $urandom_range(1)))
            begin
                send_item(ACT_FIRST, rand_elem());
                a++;
            end
            else
            begin
                send_item(ACT_SECOND, rand_elem());
                b++;
            end
        end
        send_item(ACT_COMPUTE, 16'($urandom));
    endtask

    task automatic test_reset_values();
        send_item(ACT_COMPUTE, '0);
        for (int k = 0; k < 13; k++)
        begin
            send_item(ACT_FIRST, 16'sh7FFF);
            send_item(ACT_SECOND, 16'sh8000);
        end
        send_item(ACT_COMPUTE, 16'hFFFF);
        drain();
    endtask

    task automatic test_extremes();
        write_reg(REG_FRAME_SIZE, 16'd1);
        write_reg(REG_COST_WEIGHT, 16'hFFFF);
        write_reg(REG_NORM_EN, 16'd1);
        send_item(ACT_FIRST, 16'sh7FFF);
        send_item(ACT_FIRST, 16'sh8000);
        send_item(ACT_SECOND, 16'sh8000);
        send_item(ACT_SECOND, 16'sh0000);
        send_item(ACT_SECOND, 16'sh7FFF);
        send_item(ACT_COMPUTE, '0);
        drain();
        write_reg(REG_COST_WEIGHT, 16'd0);
        write_reg(REG_NORM_EN, 16'd0);
        send_item(ACT_FIRST, 16'sh7FFF);
        send_item(ACT_SECOND, 16'sh8000);
        send_item(ACT_COMPUTE, '0);
        drain();
    endtask

    task automatic test_band();
        write_reg(REG_COST_WEIGHT, 16'd256);
        write_reg(REG_BAND_EN, 16'd1);
        write_reg(REG_BAND_RATIO, 16'd0);
        // corner lies outside a zero-width band
        load_and_compute(1, 3, 0);
        drain();
        write_reg(REG_BAND_RATIO, 16'd300);
        load_and_compute(2, 5, 0);
        drain();
        write_reg(REG_BAND_RATIO, 16'd256);
        load_and_compute(4, 3, 0);
        drain();
        write_reg(REG_BAND_EN, 16'd0);
    endtask

    task automatic test_frame_size();
        write_reg(REG_FRAME_SIZE, 16'd0);
        load_and_compute(3, 2, 0);
        drain();
        // above the feature width, with trailing partial frames
        write_reg(REG_FRAME_SIZE, 16'd31);
        load_and_compute(20, 17, 0);
        send_item(ACT_IGNORED, 16'sh1234);
        send_item(ACT_COMPUTE, '0);
        drain();
    endtask

    task automatic test_overflow();
        write_reg(REG_FRAME_SIZE, 16'd1);
        load_and_compute(FRAMES_MAX + 2, 1, 0);
        load_and_compute(2, FRAMES_MAX + 1, 0);
        drain();
    endtask

    task automatic randomize_regs();
        logic [15:0] v;
        write_reg(REG_BAND_EN, 16'($urandom_range(1)));
        case ($urandom_range(3))
            0: v = 16'd0;
            1: v = 16'd256;
            2: v = 16'd511;
            default: v = 16'($urandom_range(256));
        endcase
        write_reg(REG_BAND_RATIO, v);
        case ($urandom_range(3))
            0: v = 16'd0;
            1: v = 16'hFFFF;
            default: v = 16'($urandom);
        endcase
        write_reg(REG_COST_WEIGHT, v);
        write_reg(REG_NORM_EN, 16'($urandom_range(1)));
        if ($urandom_range(3) == 0)
            v = 16'($urandom_range(31));
        else
            v = 16'($urandom_range(1, 6));
        write_reg(REG_FRAME_SIZE, v);
    endtask

    task automatic test_random(input int n_items, input int idle, input int stall);
        int goal;
        int fs;
        feed_idle_pct = idle;
        result_stall_pct = stall;
        goal = items_sent + n_items;
        while (items_sent < goal)
        begin
            if ($urandom_range(5) == 0)
            begin
                drain();
                randomize_regs();
            end
            fs = frame_len();
            load_and_compute($urandom_range(0, 6) * fs + $urandom_range(0, 1),
                             $urandom_range(0, 6) * fs + $urandom_range(0, 1), 4);
            if ($urandom_range(19) == 0)
                drain();
        end
        drain();
        feed_idle_pct = 0;
        result_stall_pct = 0;
    endtask

    // Drive result ready and compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        dtw_outcome_t exp_o;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_costs.size() == 0)
                report_mismatch("result with no compute pending");
            else
            begin
                exp_o = expected_costs.pop_front();
                if (res_ch.distance !== exp_o.distance)
                    report_mismatch($sformatf("distance %h, expected %h",
                                              res_ch.distance, exp_o.distance));
                if (res_ch.unreachable !== exp_o.unreachable)
                    report_mismatch($sformatf("unreachable %b, expected %b",
                                              res_ch.unreachable, exp_o.unreachable));
                if (res_ch.overflowed !== exp_o.overflowed)
                    report_mismatch($sformatf("overflowed %b, expected %b",
                                              res_ch.overflowed, exp_o.overflowed));
            end
        end
        res_ch.ready <= rst_n && ($urandom_range(99) >= result_stall_pct);
    end

    initial
    begin
        #20ms;
        $display("FAIL dtw_distance_windowed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        feed_ch.valid = 1'b0;
        feed_ch.action = '0;
        feed_ch.element_value = '0;
        res_ch.ready = 1'b0;
        csr_ch.valid = 1'b0;
        csr_ch.index = '0;
        csr_ch.data = '0;
        sh_band_en = 1'b0;
        sh_ratio = RATIO_RESET;
        sh_weight = WEIGHT_RESET;
        sh_norm_en = 1'b0;
        sh_fsize = FSIZE_RESET;
        first_cnt = 0;
        second_cnt = 0;
        drop_flag = 1'b0;
        error_count = 0;
        items_sent = 0;
        feed_idle_pct = 0;
        result_stall_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_extremes();
        test_band();
        test_frame_size();
        test_overflow();
        test_random(330, 0, 0);
        test_random(330, 47, 0);
        test_random(330, 0, 47);
        test_random(330, 38, 38);

        drain();
        repeat (50) @(posedge clk);
        if (error_count == 0 && expected_costs.size() == 0)
            $display("PASS dtw_distance_windowed");
        else
            $display("FAIL dtw_distance_windowed");
        $finish;
    end

endmodule

`default_nettype wire
